@@ rtl/core/rtrd_pkg.sv @@
// Package for the rigid ray transform: widths, codes, word types.
// No dependencies; used by rtrd_lane and rigid_transform_ray_3d.
`timescale 1ns / 1ps

package rtrd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int ROT_WIDTH   = 18;
    localparam int FRAC_BITS   = 16;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = ROT_WIDTH + DIFF_W;
    localparam int TADD_W = COORD_WIDTH + FRAC_BITS;
    localparam int SUM_W  = ((PROD_W > TADD_W) ? PROD_W : TADD_W) + 2;
    localparam int SH_W   = SUM_W - FRAC_BITS;

    localparam int ROW_W      = 3 * ROT_WIDTH;
    localparam int CFG_DATA_W = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH;
    localparam int CFG_IDX_W  = 3;

    localparam int LANE_STAGES = 3;
    localparam int PIPE_DEPTH  = LANE_STAGES + 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z  = 3'd5;

    localparam logic [2:0] REQ_DIR_FWD = 3'd0;
    localparam logic [2:0] REQ_DIR_INV = 3'd1;
    localparam logic [2:0] REQ_POS_FWD = 3'd2;
    localparam logic [2:0] REQ_POS_INV = 3'd3;
    localparam logic [2:0] REQ_RAY_FWD = 3'd4;
    localparam logic [2:0] REQ_RAY_INV = 3'd5;

    localparam logic [ROT_WIDTH-1:0] ROT_ONE = ROT_WIDTH'(64'd1 << FRAC_BITS);

    typedef logic [2:0][2:0][ROT_WIDTH-1:0] t_mat;
    typedef logic [2:0][DIFF_W-1:0]         t_dvec;
    typedef logic [2:0][COORD_WIDTH-1:0]    t_cvec;

    typedef struct packed {
        logic [2:0]                    req_type;
        logic signed [COORD_WIDTH-1:0] vec_a_x;
        logic signed [COORD_WIDTH-1:0] vec_a_y;
        logic signed [COORD_WIDTH-1:0] vec_a_z;
        logic signed [COORD_WIDTH-1:0] vec_b_x;
        logic signed [COORD_WIDTH-1:0] vec_b_y;
        logic signed [COORD_WIDTH-1:0] vec_b_z;
    } t_req;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] res_a_x;
        logic signed [COORD_WIDTH-1:0] res_a_y;
        logic signed [COORD_WIDTH-1:0] res_a_z;
        logic signed [COORD_WIDTH-1:0] res_b_x;
        logic signed [COORD_WIDTH-1:0] res_b_y;
        logic signed [COORD_WIDTH-1:0] res_b_z;
        logic                          overflow;
    } t_res;

endpackage

@@ rtl/core/rigid_transform_ray_3d.sv @@
// Top level of the rigid ray transform: config registers, request decode, two lanes.
// Depends on rtrd_pkg and rtrd_lane.
//
//  channel   direction  handshake                    word
//  request   in         start, busy                  i_req  (rtrd_pkg::t_req)
//  result    out        o_res_strobe (no backpress)  o_res  (rtrd_pkg::t_res)
//  config    in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// One request enters every cycle; its result shows for one cycle, marked by o_res_strobe.
// Latency is set by the decode register plus the lane's multiply, sum and saturate stages.
// busy and o_cfg_ready are constant: the pipeline never stalls, the receiver cannot stall.
// Reset is synchronous active low; it clears the valid pipe and loads identity, zero shift.
`timescale 1ns / 1ps

module rigid_transform_ray_3d (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rtrd_pkg::t_req                      i_req,
    output logic                                o_res_strobe,
    output rtrd_pkg::t_res                      o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rtrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rtrd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW    = rtrd_pkg::COORD_WIDTH;
    localparam int RW    = rtrd_pkg::ROT_WIDTH;
    localparam int DW    = rtrd_pkg::DIFF_W;
    localparam int DEPTH = rtrd_pkg::PIPE_DEPTH;

    logic [2:0][rtrd_pkg::ROW_W-1:0] r_rot_row;
    rtrd_pkg::t_cvec                 r_shift;

    rtrd_pkg::t_mat  r_mat, n_mat;
    rtrd_pkg::t_dvec r_vec_a, n_vec_a, r_vec_b, n_vec_b;
    rtrd_pkg::t_cvec r_tadd, n_tadd;
    logic [DEPTH-1:0] r_vld;

    logic            accept;
    logic            is_inv, with_t, is_ray, is_def;
    rtrd_pkg::t_cvec va, vb, res_a, res_b;
    logic            ovf_a, ovf_b;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_row[0] <= rtrd_pkg::ROW_W'({rtrd_pkg::ROT_ONE});
            r_rot_row[1] <= rtrd_pkg::ROW_W'({rtrd_pkg::ROT_ONE, {RW{1'b0}}});
            r_rot_row[2] <= {rtrd_pkg::ROT_ONE, {(2*RW){1'b0}}};
            r_shift      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rtrd_pkg::REG_ROT_ROW0: r_rot_row[0] <= i_cfg_data[rtrd_pkg::ROW_W-1:0];
                rtrd_pkg::REG_ROT_ROW1: r_rot_row[1] <= i_cfg_data[rtrd_pkg::ROW_W-1:0];
                rtrd_pkg::REG_ROT_ROW2: r_rot_row[2] <= i_cfg_data[rtrd_pkg::ROW_W-1:0];
                rtrd_pkg::REG_SHIFT_X:  r_shift[0]   <= i_cfg_data[CW-1:0];
                rtrd_pkg::REG_SHIFT_Y:  r_shift[1]   <= i_cfg_data[CW-1:0];
                rtrd_pkg::REG_SHIFT_Z:  r_shift[2]   <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        is_inv = 1'b0;
        with_t = 1'b0;
        is_ray = 1'b0;
        is_def = 1'b1;
        unique case (i_req.req_type)
            rtrd_pkg::REQ_DIR_FWD: ;
            rtrd_pkg::REQ_DIR_INV: is_inv = 1'b1;
            rtrd_pkg::REQ_POS_FWD: with_t = 1'b1;
            rtrd_pkg::REQ_POS_INV: begin
                is_inv = 1'b1;
                with_t = 1'b1;
            end
            rtrd_pkg::REQ_RAY_FWD: begin
                with_t = 1'b1;
                is_ray = 1'b1;
            end
            rtrd_pkg::REQ_RAY_INV: begin
                is_inv = 1'b1;
                with_t = 1'b1;
                is_ray = 1'b1;
            end
            default: is_def = 1'b0;
        endcase
    end

    assign va = {i_req.vec_a_z, i_req.vec_a_y, i_req.vec_a_x};
    assign vb = {i_req.vec_b_z, i_req.vec_b_y, i_req.vec_b_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_mat[i][j] = is_inv ? r_rot_row[j][i*RW +: RW] : r_rot_row[i][j*RW +: RW];
            end
            if (!is_def) begin
                n_vec_a[i] = '0;
            end else if (is_inv && with_t) begin
                n_vec_a[i] = {va[i][CW-1], va[i]} - {r_shift[i][CW-1], r_shift[i]};
            end else begin
                n_vec_a[i] = {va[i][CW-1], va[i]};
            end
            n_vec_b[i] = is_ray ? {vb[i][CW-1], vb[i]} : {DW{1'b0}};
            n_tadd[i]  = (is_def && with_t && !is_inv) ? r_shift[i] : {CW{1'b0}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mat   <= n_mat;
        r_vec_a <= n_vec_a;
        r_vec_b <= n_vec_b;
        r_tadd  <= n_tadd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], accept};
        end
    end

    rtrd_lane u_lane_a (
        .i_clk  (i_clk),
        .i_mat  (r_mat),
        .i_vec  (r_vec_a),
        .i_tadd (r_tadd),
        .o_res  (res_a),
        .o_ovf  (ovf_a)
    );

    rtrd_lane u_lane_b (
        .i_clk  (i_clk),
        .i_mat  (r_mat),
        .i_vec  (r_vec_b),
        .i_tadd ('0),
        .o_res  (res_b),
        .o_ovf  (ovf_b)
    );

    assign o_res_strobe     = r_vld[DEPTH-1];
    assign o_res.res_a_x    = res_a[0];
    assign o_res.res_a_y    = res_a[1];
    assign o_res.res_a_z    = res_a[2];
    assign o_res.res_b_x    = res_b[0];
    assign o_res.res_b_y    = res_b[1];
    assign o_res.res_b_z    = res_b[2];
    assign o_res.overflow   = ovf_a | ovf_b;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_res_strobe)
        else $error("result strobe missing four cycles after accept");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && $past(accept && i_req.req_type[2] && i_req.req_type[1], 4))
        |-> (o_res == '0))
        else $error("undefined request produced nonzero result");

    a_nonray_b_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && $past(accept && !i_req.req_type[2], 4))
        |-> (o_res.res_b_x == '0 && o_res.res_b_y == '0 && o_res.res_b_z == '0))
        else $error("non-ray request produced nonzero second vector");

endmodule

@@ rtl/core/rtrd_lane.sv @@
// Three-stage matrix-vector lane: multiply, sum with offset, floor shift and saturate.
// Depends on rtrd_pkg.
`timescale 1ns / 1ps

module rtrd_lane (
    input  logic           i_clk,
    input  rtrd_pkg::t_mat  i_mat,
    input  rtrd_pkg::t_dvec i_vec,
    input  rtrd_pkg::t_cvec i_tadd,
    output rtrd_pkg::t_cvec o_res,
    output logic           o_ovf
);

    localparam int PROD_W = rtrd_pkg::PROD_W;
    localparam int SUM_W  = rtrd_pkg::SUM_W;
    localparam int SH_W   = rtrd_pkg::SH_W;
    localparam int CW     = rtrd_pkg::COORD_WIDTH;
    localparam int FB     = rtrd_pkg::FRAC_BITS;

    logic [2:0][2:0][PROD_W-1:0] r_prod, n_prod;
    rtrd_pkg::t_cvec             r_tadd;
    logic [2:0][SUM_W-1:0]       r_sum, n_sum;
    rtrd_pkg::t_cvec             r_res, n_res;
    logic [2:0]                  r_ovf, n_ovf;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = PROD_W'($signed(i_mat[i][j]) * $signed(i_vec[j]));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = {{(SUM_W-PROD_W){r_prod[i][0][PROD_W-1]}}, r_prod[i][0]}
                     + {{(SUM_W-PROD_W){r_prod[i][1][PROD_W-1]}}, r_prod[i][1]}
                     + {{(SUM_W-PROD_W){r_prod[i][2][PROD_W-1]}}, r_prod[i][2]}
                     + {{(SUM_W-CW-FB){r_tadd[i][CW-1]}}, r_tadd[i], {FB{1'b0}}};
        end
    end

    always_comb begin
        logic [SH_W-1:0]    sh;
        logic [SH_W-CW:0]   top;
        for (int i = 0; i < 3; i++) begin
            sh  = r_sum[i][SUM_W-1:FB];
            top = sh[SH_W-1:CW-1];
            if ((&top) || !(|top)) begin
                n_res[i] = sh[CW-1:0];
                n_ovf[i] = 1'b0;
            end else begin
                n_res[i] = sh[SH_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
                n_ovf[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_tadd <= i_tadd;
        r_sum  <= n_sum;
        r_res  <= n_res;
        r_ovf  <= n_ovf;
    end

    assign o_res = r_res;
    assign o_ovf = |r_ovf;

endmodule
